// File: hw/rtl/branch_resolve_unit_macros.svh
// ----------------------------------------------------------------------------
// branch resolve unit assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BRANCH_RESOLVE_UNIT_MACROS_SVH
`define BRANCH_RESOLVE_UNIT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define BRU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("branch resolve unit check failed");

// next-cycle implication
`define BRU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("branch resolve unit check failed");

`else

`define BRU_ASSERT_NOW(label, ante, cons)
`define BRU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/bru_pkg.sv
// ----------------------------------------------------------------------------
// bru_pkg
// shared types and constants for the branch resolve unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bru_pkg;

  localparam int XLEN   = 32;
  localparam int OP_W   = 3;
  localparam int DISP_W = 24;
  localparam int BD_W   = 14;
  localparam int BO_W   = 5;
  localparam int BI_W   = 5;

  // BO bit positions
  localparam int BO_NO_COND  = 4;
  localparam int BO_COND_VAL = 3;
  localparam int BO_NO_DEC   = 2;
  localparam int BO_CTR_ZERO = 1;

  // return address step
  localparam logic [XLEN-1:0] INSN_BYTES = XLEN'(4);

  typedef enum logic [OP_W-1:0] {
    OP_B     = 3'd0,
    OP_BC    = 3'd1,
    OP_BCLR  = 3'd2,
    OP_BCCTR = 3'd3,
    OP_RFI   = 3'd4
  } bru_op_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DISP_W-1:0] disp;
    logic              abs_addr;
    logic              link;
    logic [BO_W-1:0]   bo_field;
    logic [BI_W-1:0]   bi_field;
    logic [XLEN-1:0]   pc_in;
    logic [XLEN-1:0]   lr_in;
    logic [XLEN-1:0]   ctr_in;
    logic [XLEN-1:0]   cr_in;
    logic [XLEN-1:0]   srr0_in;
    logic [XLEN-1:0]   srr1_in;
  } bru_req_t;

  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    logic            taken;
    logic [XLEN-1:0] lr_out;
    logic            lr_write;
    logic [XLEN-1:0] ctr_out;
    logic            ctr_write;
    logic [XLEN-1:0] msr_out;
    logic            msr_write;
  } bru_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/bru_req_if.sv
// ----------------------------------------------------------------------------
// bru_req_if
// branch request channel: valid/ready with decoded fields and register values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bru_req_if;

  logic                          valid;
  logic                          ready;
  logic [bru_pkg::OP_W-1:0]      op;
  logic [bru_pkg::DISP_W-1:0]    disp;
  logic                          abs_addr;
  logic                          link;
  logic [bru_pkg::BO_W-1:0]      bo_field;
  logic [bru_pkg::BI_W-1:0]      bi_field;
  logic [bru_pkg::XLEN-1:0]      pc_in;
  logic [bru_pkg::XLEN-1:0]      lr_in;
  logic [bru_pkg::XLEN-1:0]      ctr_in;
  logic [bru_pkg::XLEN-1:0]      cr_in;
  logic [bru_pkg::XLEN-1:0]      srr0_in;
  logic [bru_pkg::XLEN-1:0]      srr1_in;

  modport source (
    output valid, op, disp, abs_addr, link, bo_field, bi_field,
           pc_in, lr_in, ctr_in, cr_in, srr0_in, srr1_in,
    input  ready
  );

  modport sink (
    input  valid, op, disp, abs_addr, link, bo_field, bi_field,
           pc_in, lr_in, ctr_in, cr_in, srr0_in, srr1_in,
    output ready
  );

endinterface

`default_nettype wire

// File: hw/rtl/bru_rsp_if.sv
// ----------------------------------------------------------------------------
// bru_rsp_if
// branch result channel: valid/ready with next pc and register updates
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bru_rsp_if;

  logic                     valid;
  logic                     ready;
  logic [bru_pkg::XLEN-1:0] next_pc;
  logic                     taken;
  logic [bru_pkg::XLEN-1:0] lr_out;
  logic                     lr_write;
  logic [bru_pkg::XLEN-1:0] ctr_out;
  logic                     ctr_write;
  logic [bru_pkg::XLEN-1:0] msr_out;
  logic                     msr_write;

  modport source (
    output valid, next_pc, taken, lr_out, lr_write, ctr_out, ctr_write,
           msr_out, msr_write,
    input  ready
  );

  modport sink (
    input  valid, next_pc, taken, lr_out, lr_write, ctr_out, ctr_write,
           msr_out, msr_write,
    output ready
  );

endinterface

`default_nettype wire

// File: hw/rtl/bru_resolve.sv
// ----------------------------------------------------------------------------
// bru_resolve
// combinational branch evaluation: target, BO/BI tests and register updates
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bru_resolve (
  input  bru_pkg::bru_req_t req,
  output bru_pkg::bru_rsp_t rsp
);

  import bru_pkg::*;

  logic [XLEN-1:0] off_li;
  logic [XLEN-1:0] off_bd;
  logic [XLEN-1:0] tgt_b;
  logic [XLEN-1:0] tgt_bc;
  logic [XLEN-1:0] tgt_cond;
  logic [XLEN-1:0] ctr_dec;
  logic [XLEN-1:0] ret_addr;
  logic            do_dec;
  logic            ctr_ok;
  logic            cond_ok;
  logic            cr_bit;
  logic            is_cond;

  assign off_li = {{(XLEN-DISP_W-2){req.disp[DISP_W-1]}}, req.disp, 2'b00};
  assign off_bd = {{(XLEN-BD_W-2){req.disp[BD_W-1]}}, req.disp[BD_W-1:0], 2'b00};
  assign tgt_b  = req.abs_addr ? off_li : req.pc_in + off_li;
  assign tgt_bc = req.abs_addr ? off_bd : req.pc_in + off_bd;

  assign ctr_dec  = req.ctr_in - XLEN'(1);
  assign ret_addr = req.pc_in + INSN_BYTES;

  // bit 0 of bi is the msb of cr, so index 31 - bi is just ~bi
  assign cr_bit = req.cr_in[~req.bi_field];

  assign do_dec  = !req.bo_field[BO_NO_DEC];
  assign ctr_ok  = !do_dec ||
                   (req.bo_field[BO_CTR_ZERO] ? (ctr_dec == '0) : (ctr_dec != '0));
  assign cond_ok = req.bo_field[BO_NO_COND] || (cr_bit == req.bo_field[BO_COND_VAL]);

  always_comb begin
    is_cond  = 1'b0;
    tgt_cond = tgt_bc;
    unique case (req.op)
      OP_BC: begin
        is_cond  = 1'b1;
        tgt_cond = tgt_bc;
      end
      OP_BCLR: begin
        is_cond  = 1'b1;
        tgt_cond = {req.lr_in[XLEN-1:2], 2'b00};
      end
      OP_BCCTR: begin
        is_cond  = 1'b1;
        tgt_cond = {req.ctr_in[XLEN-1:2], 2'b00};
      end
      default: begin
        is_cond  = 1'b0;
        tgt_cond = tgt_bc;
      end
    endcase
  end

  always_comb begin
    rsp.next_pc   = req.pc_in;
    rsp.taken     = 1'b0;
    rsp.ctr_out   = req.ctr_in;
    rsp.ctr_write = 1'b0;
    rsp.msr_out   = '0;
    rsp.msr_write = 1'b0;
    if (req.op == OP_B) begin
      rsp.next_pc = tgt_b;
      rsp.taken   = 1'b1;
    end else if (is_cond) begin
      if (do_dec) begin
        rsp.ctr_out   = ctr_dec;
        rsp.ctr_write = 1'b1;
      end
      if (ctr_ok && cond_ok) begin
        rsp.next_pc = tgt_cond;
        rsp.taken   = 1'b1;
      end
    end else if (req.op == OP_RFI) begin
      rsp.next_pc   = {req.srr0_in[XLEN-1:2], 2'b00};
      rsp.taken     = 1'b1;
      rsp.msr_out   = req.srr1_in;
      rsp.msr_write = 1'b1;
    end
    // rfi never links
    rsp.lr_write = rsp.taken && req.link && (req.op != OP_RFI);
    rsp.lr_out   = rsp.lr_write ? ret_addr : req.lr_in;
  end

endmodule

`default_nettype wire

// File: hw/rtl/branch_resolve_unit.sv
// A branch is resolved in one pass: an accepted transaction is captured in the
// input register, evaluated by the target adders and BO/BI test logic, and its
// result lands in the output register, from which it is offered until taken.
// One transaction is taken every cycle unless both stages are full and the
// result is stalled; the two register stages hand off with a ready chain, so
// a stalled result does not block a new transaction from entering the input
// register while it is free.
// ----------------------------------------------------------------------------
// branch_resolve_unit
// registered PowerPC branch resolution for b, bc, bclr, bcctr and rfi
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "branch_resolve_unit_macros.svh"

module branch_resolve_unit (
  input  wire       clk,
  input  wire       rst_n,
  bru_req_if.sink   in_ch,
  bru_rsp_if.source out_ch
);

  import bru_pkg::*;

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  bru_req_t s1_req_r;
  logic     out_valid_r;
  logic     out_valid_nxt;
  bru_rsp_t out_rsp_r;
  bru_rsp_t rsp_nxt;
  bru_req_t in_req;
  logic     s1_ready;
  logic     s2_ready;

  assign in_req = '{
    op:       in_ch.op,
    disp:     in_ch.disp,
    abs_addr: in_ch.abs_addr,
    link:     in_ch.link,
    bo_field: in_ch.bo_field,
    bi_field: in_ch.bi_field,
    pc_in:    in_ch.pc_in,
    lr_in:    in_ch.lr_in,
    ctr_in:   in_ch.ctr_in,
    cr_in:    in_ch.cr_in,
    srr0_in:  in_ch.srr0_in,
    srr1_in:  in_ch.srr1_in
  };

  bru_resolve u_resolve (
    .req (s1_req_r),
    .rsp (rsp_nxt)
  );

  assign s2_ready = !out_valid_r || out_ch.ready;
  assign s1_ready = !s1_valid_r || s2_ready;

  assign s1_valid_nxt  = s1_ready ? in_ch.valid : s1_valid_r;
  assign out_valid_nxt = s2_ready ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      s1_req_r <= in_req;
    end
    if (s2_ready && s1_valid_r) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign in_ch.ready = s1_ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.next_pc   = out_rsp_r.next_pc;
  assign out_ch.taken     = out_rsp_r.taken;
  assign out_ch.lr_out    = out_rsp_r.lr_out;
  assign out_ch.lr_write  = out_rsp_r.lr_write;
  assign out_ch.ctr_out   = out_rsp_r.ctr_out;
  assign out_ch.ctr_write = out_rsp_r.ctr_write;
  assign out_ch.msr_out   = out_rsp_r.msr_out;
  assign out_ch.msr_write = out_rsp_r.msr_write;

  // an evaluated branch always reaches the output register
  `BRU_ASSERT_NEXT(a_s1_advance, s1_valid_r && s2_ready, out_valid_r)
  // a full input stage is kept while the output is stalled
  `BRU_ASSERT_NEXT(a_s1_hold, s1_valid_r && out_valid_r && !out_ch.ready, s1_valid_r)
  // linking only happens on a taken branch that is not rfi
  `BRU_ASSERT_NOW(a_link_taken, out_valid_r && out_ch.lr_write, out_ch.taken && !out_ch.msr_write)

endmodule

`default_nettype wire

// File: verif/bru_resolve_monitor.sv
// ----------------------------------------------------------------------------
// bru_resolve_monitor
// watches both branch channels, predicts each resolved branch from the
// accepted request and compares it field by field with what comes out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bru_resolve_monitor (
  input  logic clk,
  input  logic rst_n,
  bru_req_if   req_mon,
  bru_rsp_if   rsp_mon,
  output int   error_count,
  output int   outstanding
);

  import bru_pkg::*;

  bru_rsp_t pending_results[$];

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  function automatic bru_rsp_t resolve_branch(bru_req_t r);
    bru_rsp_t        res;
    logic [XLEN-1:0] off;
    logic [XLEN-1:0] target;
    logic            ctr_ok;
    logic            cond_ok;
    res.next_pc   = r.pc_in;
    res.taken     = 1'b0;
    res.lr_out    = r.lr_in;
    res.lr_write  = 1'b0;
    res.ctr_out   = r.ctr_in;
    res.ctr_write = 1'b0;
    res.msr_out   = '0;
    res.msr_write = 1'b0;
    case (r.op)
      OP_B: begin
        // LI is 24 bits, word aligned, sign taken from the top of the 26-bit offset
        off         = {{6{r.disp[DISP_W-1]}}, r.disp, 2'b00};
        res.next_pc = r.abs_addr ? off : r.pc_in + off;
        res.taken   = 1'b1;
      end
      OP_BC, OP_BCLR, OP_BCCTR: begin
        if (r.op == OP_BC) begin
          off    = {{16{r.disp[BD_W-1]}}, r.disp[BD_W-1:0], 2'b00};
          target = r.abs_addr ? off : r.pc_in + off;
        end else if (r.op == OP_BCLR) begin
          target = {r.lr_in[XLEN-1:2], 2'b00};
        end else begin
          // count target uses the value from before the decrement
          target = {r.ctr_in[XLEN-1:2], 2'b00};
        end
        ctr_ok  = 1'b1;
        cond_ok = 1'b1;
        if (!r.bo_field[BO_NO_DEC]) begin
          res.ctr_out   = r.ctr_in - 1;
          res.ctr_write = 1'b1;
          ctr_ok = r.bo_field[BO_CTR_ZERO] ? (res.ctr_out == '0) : (res.ctr_out != '0);
        end
        if (!r.bo_field[BO_NO_COND])
          cond_ok = (r.cr_in[XLEN-1-r.bi_field] == r.bo_field[BO_COND_VAL]);
        if (ctr_ok && cond_ok) begin
          res.next_pc = target;
          res.taken   = 1'b1;
        end
      end
      OP_RFI: begin
        res.next_pc   = {r.srr0_in[XLEN-1:2], 2'b00};
        res.msr_out   = r.srr1_in;
        res.msr_write = 1'b1;
        res.taken     = 1'b1;
      end
      default: ;
    endcase
    if (res.taken && r.link && r.op != OP_RFI) begin
      res.lr_out   = r.pc_in + INSN_BYTES;
      res.lr_write = 1'b1;
    end
    return res;
  endfunction

  task automatic note_failure(input string what);
    error_count++;
    if (error_count <= 10)
      $display("[%0t] branch result error:%s", $time, what);
  endtask

  // channels only change at the rising edge, so the falling edge sees stable values
  always @(negedge clk) begin : watch
    bru_req_t req;
    bru_rsp_t got;
    bru_rsp_t want;
    string    diffs;
    if (rst_n) begin
      if (req_mon.valid && req_mon.ready) begin
        req.op       = req_mon.op;
        req.disp     = req_mon.disp;
        req.abs_addr = req_mon.abs_addr;
        req.link     = req_mon.link;
        req.bo_field = req_mon.bo_field;
        req.bi_field = req_mon.bi_field;
        req.pc_in    = req_mon.pc_in;
        req.lr_in    = req_mon.lr_in;
        req.ctr_in   = req_mon.ctr_in;
        req.cr_in    = req_mon.cr_in;
        req.srr0_in  = req_mon.srr0_in;
        req.srr1_in  = req_mon.srr1_in;
        pending_results.push_back(resolve_branch(req));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.next_pc   = rsp_mon.next_pc;
        got.taken     = rsp_mon.taken;
        got.lr_out    = rsp_mon.lr_out;
        got.lr_write  = rsp_mon.lr_write;
        got.ctr_out   = rsp_mon.ctr_out;
        got.ctr_write = rsp_mon.ctr_write;
        got.msr_out   = rsp_mon.msr_out;
        got.msr_write = rsp_mon.msr_write;
        if (pending_results.size() == 0) begin
          note_failure($sformatf(" result transaction with no branch outstanding, next_pc %h",
                                 got.next_pc));
        end else begin
          want  = pending_results.pop_front();
          diffs = "";
          if (got.next_pc !== want.next_pc)
            diffs = {diffs, $sformatf(" next_pc exp %h got %h", want.next_pc, got.next_pc)};
          if (got.taken !== want.taken)
            diffs = {diffs, $sformatf(" taken exp %b got %b", want.taken, got.taken)};
          if (got.lr_out !== want.lr_out)
            diffs = {diffs, $sformatf(" lr_out exp %h got %h", want.lr_out, got.lr_out)};
          if (got.lr_write !== want.lr_write)
            diffs = {diffs, $sformatf(" lr_write exp %b got %b", want.lr_write, got.lr_write)};
          if (got.ctr_out !== want.ctr_out)
            diffs = {diffs, $sformatf(" ctr_out exp %h got %h", want.ctr_out, got.ctr_out)};
          if (got.ctr_write !== want.ctr_write)
            diffs = {diffs, $sformatf(" ctr_write exp %b got %b", want.ctr_write,
                                      got.ctr_write)};
          if (got.msr_out !== want.msr_out)
            diffs = {diffs, $sformatf(" msr_out exp %h got %h", want.msr_out, got.msr_out)};
          if (got.msr_write !== want.msr_write)
            diffs = {diffs, $sformatf(" msr_write exp %b got %b", want.msr_write,
                                      got.msr_write)};
          if (diffs != "")
            note_failure(diffs);
        end
      end
      outstanding = pending_results.size();
    end
  end

endmodule

// File: verif/branch_resolve_unit_tb.sv
// ----------------------------------------------------------------------------
// branch_resolve_unit_tb
// drives directed and random branches of every kind through the unit with
// random idle bursts on both channels; the monitor predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module branch_resolve_unit_tb;
  import bru_pkg::*;

  localparam int CLK_PERIOD  = 4;
  localparam int RANDOM_CNT  = 1550;
  localparam int CALM_TAIL   = 200;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  int   error_count;
  int   outstanding;
  int   stall_left;

  bru_req_if in_ch ();
  bru_rsp_if out_ch ();

  branch_resolve_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bru_resolve_monitor monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (in_ch),
    .rsp_mon     (out_ch),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0 && !calm) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 12) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 8);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic push_branch(input bru_req_t r);
    if (!calm && $urandom_range(0, 99) < 15) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= r.op;
    in_ch.disp     <= r.disp;
    in_ch.abs_addr <= r.abs_addr;
    in_ch.link     <= r.link;
    in_ch.bo_field <= r.bo_field;
    in_ch.bi_field <= r.bi_field;
    in_ch.pc_in    <= r.pc_in;
    in_ch.lr_in    <= r.lr_in;
    in_ch.ctr_in   <= r.ctr_in;
    in_ch.cr_in    <= r.cr_in;
    in_ch.srr0_in  <= r.srr0_in;
    in_ch.srr1_in  <= r.srr1_in;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
  endtask

  task automatic push_fixed(input logic [OP_W-1:0] op, input logic [DISP_W-1:0] disp,
                            input logic aa, input logic lk, input logic [BO_W-1:0] bo,
                            input logic [BI_W-1:0] bi, input logic [XLEN-1:0] pc,
                            input logic [XLEN-1:0] lr, input logic [XLEN-1:0] ctr,
                            input logic [XLEN-1:0] cr, input logic [XLEN-1:0] srr0,
                            input logic [XLEN-1:0] srr1);
    bru_req_t r;
    r = '{op, disp, aa, lk, bo, bi, pc, lr, ctr, cr, srr0, srr1};
    push_branch(r);
  endtask

  function automatic bru_req_t random_branch();
    bru_req_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 20)      r.op = OP_B;
    else if (pick < 50) r.op = OP_BC;
    else if (pick < 65) r.op = OP_BCLR;
    else if (pick < 80) r.op = OP_BCCTR;
    else if (pick < 92) r.op = OP_RFI;
    else                r.op = OP_W'($urandom_range(5, 7));
    r.disp     = DISP_W'($urandom);
    r.abs_addr = 1'($urandom);
    r.link     = 1'($urandom);
    r.bo_field = BO_W'($urandom);
    r.bi_field = BI_W'($urandom);
    r.pc_in    = $urandom;
    r.lr_in    = $urandom;
    r.cr_in    = $urandom;
    r.srr0_in  = $urandom;
    r.srr1_in  = $urandom;
    // small counts make the zero test go both ways
    pick = $urandom_range(0, 99);
    if (pick < 40)      r.ctr_in = $urandom_range(0, 3);
    else if (pick < 50) r.ctr_in = '1;
    else                r.ctr_in = $urandom;
    return r;
  endfunction

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.op       = '0;
    in_ch.disp     = '0;
    in_ch.abs_addr = 1'b0;
    in_ch.link     = 1'b0;
    in_ch.bo_field = '0;
    in_ch.bi_field = '0;
    in_ch.pc_in    = '0;
    in_ch.lr_in    = '0;
    in_ch.ctr_in   = '0;
    in_ch.cr_in    = '0;
    in_ch.srr0_in  = '0;
    in_ch.srr1_in  = '0;
    out_ch.ready   = 1'b0;
    rst_n          = 1'b0;
    calm           = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // b: offset extremes, absolute and relative, return address wrap
    push_fixed(OP_B, 24'h7FFFFF, 0, 1, 0, 0, 32'hFFFFFFF0, 32'h11111111, 5, 0, 0, 0);
    push_fixed(OP_B, 24'h800000, 0, 0, 0, 0, 32'h00000100, 32'h22222222, 5, 0, 0, 0);
    push_fixed(OP_B, 24'hFFFFFF, 1, 0, 5'h1F, 31, 32'h12345678, 0, 0, '1, 0, 0);
    push_fixed(OP_B, 24'h000000, 1, 1, 0, 0, 32'hFFFFFFFC, '1, '1, 0, '1, '1);
    // bc: upper displacement bits ignored, displacement extremes
    push_fixed(OP_BC, 24'hFFDFFF, 0, 0, 5'h14, 0, 32'h00001000, 0, 7, 0, 0, 0);
    push_fixed(OP_BC, 24'h002000, 1, 1, 5'h14, 0, 32'h80000000, 0, 7, 0, 0, 0);
    // bc: count reaches zero, tested both ways
    push_fixed(OP_BC, 24'h000010, 0, 1, 5'h00, 0, 32'h00002000, 0, 1, 0, 0, 0);
    push_fixed(OP_BC, 24'h000010, 0, 1, 5'h02, 0, 32'h00002000, 0, 1, 0, 0, 0);
    // bc: condition bit at the least significant cr position, taken and not taken
    push_fixed(OP_BC, 24'h000020, 0, 1, 5'h0C, 31, 32'h00003000, 0, 9, 32'h1, 0, 0);
    push_fixed(OP_BC, 24'h000020, 0, 1, 5'h0C, 31, 32'h00003000, 0, 9, 32'hFFFFFFFE, 0, 0);
    // bc: count wraps from zero
    push_fixed(OP_BC, 24'h000004, 0, 0, 5'h10, 0, 32'h00004000, 0, 0, 0, 0, 0);
    push_fixed(OP_BC, 24'h000004, 0, 0, 5'h12, 0, 32'h00004000, 0, 0, 0, 0, 0);
    push_fixed(OP_BC, 24'h003FFF, 0, 1, 5'h1F, 17, 32'h00005000, 0, 0, 0, 0, 0);
    push_fixed(OP_BC, 24'h000008, 0, 0, 5'h08, 0, 32'h00006000, 0, 3, 32'h80000000, 0, 0);
    // bclr: low target bits cleared, link register replaced
    push_fixed(OP_BCLR, 0, 0, 1, 5'h14, 0, 32'h00007000, '1, 4, 0, 0, 0);
    push_fixed(OP_BCLR, 0, 0, 0, 5'h00, 0, 32'h00007000, 32'h00ABCDEF, 2, 0, 0, 0);
    // bcctr: target from the count before the decrement
    push_fixed(OP_BCCTR, 0, 0, 1, 5'h14, 0, 32'h00008000, 0, 32'h12345677, 0, 0, 0);
    push_fixed(OP_BCCTR, 0, 0, 0, 5'h10, 0, 32'h00008000, 0, 5, 0, 0, 0);
    push_fixed(OP_BCCTR, 0, 0, 1, 5'h12, 0, 32'h00008000, 0, 1, 0, 0, 0);
    // rfi: full machine state, link ignored
    push_fixed(OP_RFI, 0, 0, 1, 0, 0, 32'h00009000, 0, 0, 0, '1, '1);
    push_fixed(OP_RFI, '1, 1, 0, '1, '1, '1, '1, '1, '1, 0, 0);
    // unused opcodes leave everything untouched
    push_fixed(3'd5, '1, 1, 1, 0, 0, 32'h0000A000, 32'h1, 32'h2, 0, '1, '1);
    push_fixed(3'd6, 0, 0, 1, 5'h14, 0, 32'h0000B000, 32'h3, 32'h4, '1, '1, '1);
    push_fixed(3'd7, '1, 0, 1, '1, '1, '1, '1, 0, '1, '1, '1);

    for (int i = 0; i < RANDOM_CNT; i++) begin
      if (i >= RANDOM_CNT - CALM_TAIL)
        calm = 1'b1;
      push_branch(random_branch());
    end
    in_ch.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: branch_resolve_unit.f
+incdir+hw/rtl
hw/rtl/bru_pkg.sv
hw/rtl/bru_req_if.sv
hw/rtl/bru_rsp_if.sv
hw/rtl/bru_resolve.sv
hw/rtl/branch_resolve_unit.sv
verif/bru_resolve_monitor.sv
verif/branch_resolve_unit_tb.sv
